// ----- rtl/tgapsd_pkg.sv -----
// Shared types, codes and constants for the TGA pixel stream decoder.
package tgapsd_pkg;

    // Default depth of the queue between the byte classifier and the pixel engine.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_RUN_LENGTH_MODE  = 3'd0;
    localparam logic [2:0] REG_FOUR_BYTE_PIXELS = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH      = 3'd2;
    localparam logic [2:0] REG_IMAGE_HEIGHT     = 3'd3;
    localparam logic [2:0] REG_ALPHA_FILL       = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] IMAGE_DIM_RESET  = 16'd1;
    localparam logic [7:0]  ALPHA_FILL_RESET = 8'hFF;

    // Packet headers below this value start a raw packet.
    localparam logic [7:0] RUN_HEADER_MIN = 8'd128;
    // A run header carries its length plus this offset.
    localparam logic [7:0] RUN_LEN_OFFSET = 8'd127;

    // Packet decode phase.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RAW    = 2'd1,
        PH_RUN    = 2'd2
    } phase_t;

    // One classified byte as it waits in the queue.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start;      // clear the decoder before this byte
        logic       hdr_is_run; // byte read as a header starts a run
        logic [7:0] hdr_count;  // pixel count if read as a header
    } byte_entry_t;

    // Configuration as seen by the pixel engine.
    typedef struct packed {
        logic        run_length_mode;
        logic        four_byte_pixels;
        logic [7:0]  alpha_fill;
        logic [31:0] total_pixels;
    } dec_cfg_t;

endpackage

// ----- rtl/tgapsd_front.sv -----
// Input side: takes stream bytes and classifies each as a potential packet header.
module tgapsd_front
    import tgapsd_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        q_full,
    output logic        q_push,
    output byte_entry_t q_entry
);

    // A transfer is taken whenever the queue has a free slot.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Header decode does not depend on decoder state, so it is done here.
    always_comb begin
        q_entry.data_byte = s_tdata;
        q_entry.start     = s_tuser;
        if (s_tdata < RUN_HEADER_MIN) begin
            q_entry.hdr_is_run = 1'b0;
            q_entry.hdr_count  = s_tdata + 8'd1;
        end else begin
            q_entry.hdr_is_run = 1'b1;
            q_entry.hdr_count  = s_tdata - RUN_LEN_OFFSET;
        end
    end

endmodule

// ----- rtl/tgapsd_queue.sv -----
// Small queue of classified bytes between the front and the pixel engine.
module tgapsd_queue
    import tgapsd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF // at least 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  byte_entry_t push_entry,
    input  logic        pop,
    output logic        head_valid,
    output byte_entry_t head_entry,
    output logic        full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    byte_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_entry = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/tgapsd_back.sv -----
// Pixel engine: packet state, pixel assembly, run clipping and the output register.
module tgapsd_back
    import tgapsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dec_cfg_t    cfg,
    input  logic        q_valid,
    input  byte_entry_t q_entry,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tlast
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  bip_reg, bip_next;
    logic [23:0] held_reg, held_next;
    logic [31:0] done_reg, done_next;

    logic        m_valid_reg, m_valid_next;
    logic [39:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    // State as seen after an optional start-of-image clear.
    phase_t      eff_phase;
    logic [7:0]  eff_left;
    logic [1:0]  eff_bip;
    logic [23:0] eff_held;
    logic [31:0] eff_done;

    logic        complete;
    logic        is_header;
    logic        collect;
    logic [1:0]  last_idx;
    logic [31:0] remaining;
    logic        rem_small;
    logic [7:0]  left_dec;
    logic [7:0]  run_cnt;
    logic [7:0]  repeat_cnt;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic        produce;

    // A byte leaves the queue when the output register can take its result.
    assign q_pop = q_valid && (!m_valid_reg || m_tready);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Start of image clears the decoder before the byte is used.
    always_comb begin
        if (q_entry.start) begin
            eff_phase = PH_HEADER;
            eff_left  = '0;
            eff_bip   = '0;
            eff_held  = '0;
            eff_done  = '0;
        end else begin
            eff_phase = phase_reg;
            eff_left  = left_reg;
            eff_bip   = bip_reg;
            eff_held  = held_reg;
            eff_done  = done_reg;
        end
    end

    // Byte classification against the current state.
    assign complete  = (eff_done >= cfg.total_pixels);
    assign remaining = cfg.total_pixels - eff_done;
    assign rem_small = (remaining[31:8] == '0);
    assign is_header = cfg.run_length_mode && (eff_phase == PH_HEADER);
    assign last_idx  = cfg.four_byte_pixels ? 2'd3 : 2'd2;
    assign collect   = (eff_bip < last_idx);
    assign left_dec  = (eff_left == '0) ? '0 : eff_left - 8'd1;

    // Next packet phase.
    always_comb begin
        phase_next = phase_reg;
        if (q_pop) begin
            phase_next = eff_phase;
            if (!complete) begin
                if (is_header) begin
                    phase_next = q_entry.hdr_is_run ? PH_RUN : PH_RAW;
                end else if (!collect && cfg.run_length_mode) begin
                    if (eff_phase == PH_RUN || left_dec == '0) begin
                        phase_next = PH_HEADER;
                    end
                end
            end
        end
    end

    // Pixel values and run length of a completed pixel.
    always_comb begin
        red   = (eff_bip == 2'd2) ? q_entry.data_byte : eff_held[23:16];
        alpha = (cfg.four_byte_pixels && eff_bip == 2'd3) ? q_entry.data_byte
                                                           : cfg.alpha_fill;
        if (cfg.run_length_mode && eff_phase == PH_RUN) begin
            run_cnt = (eff_left == '0) ? 8'd1 : eff_left;
        end else begin
            run_cnt = 8'd1;
        end
        // Clip the run to the pixels still missing from the image.
        if (rem_small && run_cnt > remaining[7:0]) begin
            repeat_cnt = remaining[7:0];
        end else begin
            repeat_cnt = run_cnt;
        end
    end

    // Datapath state and output register.
    always_comb begin
        left_next    = left_reg;
        bip_next     = bip_reg;
        held_next    = held_reg;
        done_next    = done_reg;
        produce      = 1'b0;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            left_next = eff_left;
            bip_next  = eff_bip;
            held_next = eff_held;
            done_next = eff_done;
            if (!complete) begin
                if (is_header) begin
                    left_next = q_entry.hdr_count;
                    bip_next  = '0;
                    held_next = '0;
                end else if (collect) begin
                    case (eff_bip)
                        2'd0:    held_next[7:0]   = eff_held[7:0]   | q_entry.data_byte;
                        2'd1:    held_next[15:8]  = eff_held[15:8]  | q_entry.data_byte;
                        default: held_next[23:16] = eff_held[23:16] | q_entry.data_byte;
                    endcase
                    bip_next = eff_bip + 2'd1;
                end else begin
                    produce = 1'b1;
                    if (cfg.run_length_mode) begin
                        left_next = (eff_phase == PH_RUN) ? '0 : left_dec;
                    end
                    done_next   = eff_done + 32'(repeat_cnt);
                    bip_next    = '0;
                    held_next   = '0;
                    m_data_next = {repeat_cnt, alpha, eff_held[7:0], eff_held[15:8], red};
                    m_last_next = rem_small && (repeat_cnt == remaining[7:0]);
                end
            end
            m_valid_next = produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            left_reg    <= '0;
            bip_reg     <= '0;
            held_reg    <= '0;
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            bip_reg     <= bip_next;
            held_reg    <= held_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

endmodule

// ----- rtl/tga_pixel_stream_decoder.sv -----
// Top level of the TGA pixel stream decoder: configuration registers and channel wiring.
//
// Usage: pixel-data bytes of a TGA image (after the file header) arrive one per
// transfer on the s_ channel; s_tuser marks the first byte of a new image and
// clears the decoder first. Plain or run-length packets are selected by register.
// Each completed pixel leaves as one m_ transfer with red, green, blue, alpha and
// a repeat count (a run packet gives one transfer for the whole run, clipped at
// the image end). m_tlast marks the transfer that completes the image; later
// bytes are dropped until the next start of image.
// Throughput: one byte per cycle while m_tready stays high. A byte that
// completes a pixel is written into the byte queue, then its result moves into
// the output register, which raises m_tvalid.
// The image size product is taken into its own register after a write.
// When the receiver stalls, the result holds in the output register, the byte
// queue fills and s_tready drops once it is full; nothing is lost.
// Reset (aresetn low, synchronous) empties the queue and the output register,
// clears the decoder state and loads the register defaults.
// The user must make configuration writes only while the block is idle; the block itself does not enforce it.
module tga_pixel_stream_decoder
    import tgapsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_image
    // Decoded pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                   // [31:24] alpha, [39:32] repeat_count
    output logic        m_tlast,   // last_pixel
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic        run_length_mode_reg;
    logic        four_byte_pixels_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [7:0]  alpha_fill_reg;
    logic [31:0] total_reg;

    dec_cfg_t    dec_cfg;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_valid;
    byte_entry_t push_entry;
    byte_entry_t head_entry;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_length_mode_reg  <= 1'b0;
            four_byte_pixels_reg <= 1'b0;
            image_width_reg      <= IMAGE_DIM_RESET;
            image_height_reg     <= IMAGE_DIM_RESET;
            alpha_fill_reg       <= ALPHA_FILL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RUN_LENGTH_MODE:  run_length_mode_reg  <= cfg_wdata[0];
                REG_FOUR_BYTE_PIXELS: four_byte_pixels_reg <= cfg_wdata[0];
                REG_IMAGE_WIDTH:      image_width_reg      <= cfg_wdata;
                REG_IMAGE_HEIGHT:     image_height_reg     <= cfg_wdata;
                REG_ALPHA_FILL:       alpha_fill_reg       <= cfg_wdata[7:0];
                default:              ;
            endcase
        end
    end

    // Pixel count of the image, registered after the multiplier.
    always_ff @(posedge aclk) begin
        total_reg <= 32'(image_width_reg) * 32'(image_height_reg);
    end

    assign dec_cfg.run_length_mode  = run_length_mode_reg;
    assign dec_cfg.four_byte_pixels = four_byte_pixels_reg;
    assign dec_cfg.alpha_fill       = alpha_fill_reg;
    assign dec_cfg.total_pixels     = total_reg;

    tgapsd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    tgapsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry),
        .full       (q_full)
    );

    tgapsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (dec_cfg),
        .q_valid  (q_valid),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A pixel always covers at least one and at most RUN_HEADER_MIN (128) pixels.
    a_repeat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39:32] != 8'd0 && m_tdata[39:32] <= RUN_HEADER_MIN))
        else $error("repeat_count out of range");

    // Without run-length packets every pixel stands alone.
    a_plain_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !run_length_mode_reg) |-> (m_tdata[39:32] == 8'd1))
        else $error("plain mode pixel with repeat count other than one");

    // 24-bit pixels take their alpha from the fill register.
    a_alpha_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !four_byte_pixels_reg) |-> (m_tdata[31:24] == alpha_fill_reg))
        else $error("24-bit pixel alpha differs from fill value");

    // A popped byte never leaves the queue while the output register is stalled.
    a_no_pop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !q_pop)
        else $error("byte consumed while result stalled");

endmodule
